>>> rtl/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

>>> rtl/dnsd_pkg.sv
`default_nettype none

package dnsd_pkg;

	// Storage sizes.
	localparam int PACKET_BYTES = 4096;
	localparam int NAME_BYTES   = 256;
	localparam int ADDR_W       = $clog2(PACKET_BYTES);

	// Fixed field widths of the stream items.
	localparam int IN_ADDR_W  = 12;
	localparam int PLEN_W     = 13;
	localparam int POS_W      = 14;
	localparam int CMP_W      = 16;
	localparam int NLEN_W     = 9;
	localparam int CONS_W     = 9;
	localparam int JUMP_W     = 8;
	localparam int LABEL_W    = 6;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 48;

	// Byte constants of the name format.
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	// Completion codes of a decode.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNC_PTR = 3'd1,
		ST_JUMPS     = 3'd2,
		ST_BAD_LABEL = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_NO_END    = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    wr;
		logic    rd_pos;
		logic    rd_next;
		logic    take_zero;
		logic    take_label;
		logic    jump;
		logic    push_dot;
		logic    push_byte;
		logic    finish;
		status_t fin_status;
	} cmd_t;

	// Conditions reported by the datapath.
	typedef struct packed {
		logic at_end;
		logic is_ptr;
		logic ptr_trunc;
		logic is_zero;
		logic bad_label;
		logic jump_over;
		logic rem_zero;
		logic name_full;
		logic name_started;
		logic push_ok;
		logic can_emit;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/dnsd_ram.sv
`default_nettype none

// Simple dual-port RAM with a registered read port.
module dnsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and read port; read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/dnsd_dp.sv
`default_nettype none

module dnsd_dp import dnsd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output      stat_t                 stat,
	input  wire logic [IN_ADDR_W-1:0]  in_address,
	input  wire logic [7:0]            in_data_byte,
	input  wire logic [PLEN_W-1:0]     in_packet_length,
	input  wire logic                  cfg_we,
	input  wire logic [JUMP_W-1:0]     cfg_value,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [M_TDATA_W-1:0]  m_tdata,
	output      logic                  m_tlast
);

	logic [POS_W-1:0]     pos_q;
	logic [PLEN_W-1:0]    blen_q;
	logic [JUMP_W-1:0]    jump_q;
	logic [JUMP_W-1:0]    max_q;
	logic [LABEL_W-1:0]   rem_q;
	logic [NLEN_W-1:0]    nlen_q;
	logic [CONS_W-1:0]    cons_q;
	logic                 seen_q;
	logic [23:0]          chunk_q;
	logic [LABEL_W-1:0]   hi_q;
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                 out_last_q;

	logic [7:0]           rdata;
	logic                 ram_we;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [CMP_W-1:0]     pos_ext;
	logic [CMP_W-1:0]     blen_ext;
	logic [CMP_W-1:0]     label_end;
	logic [PLEN_W-1:0]    blen_next;
	logic [POS_W-1:0]     target;
	logic [7:0]           push_ch;
	logic                 push;
	logic                 idx3;
	logic [CONS_W-1:0]    cons_out;

	// Packet store.
	assign ram_we    = cmd.wr && (CMP_W'(in_address) < CMP_W'(PACKET_BYTES));
	assign ram_re    = cmd.rd_pos || cmd.rd_next;
	assign ram_raddr = cmd.rd_next ? ADDR_W'(pos_q + POS_W'(1)) : pos_q[ADDR_W-1:0];

	dnsd_ram #(
		.WIDTH(8),
		.DEPTH(PACKET_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(in_address)),
		.wdata (in_data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Position and length comparisons.
	assign pos_ext   = CMP_W'(pos_q);
	assign blen_ext  = CMP_W'(blen_q);
	assign label_end = pos_ext + CMP_W'(1) + CMP_W'(rdata);
	assign blen_next = (CMP_W'(in_packet_length) > CMP_W'(PACKET_BYTES)) ?
		PLEN_W'(PACKET_BYTES) : in_packet_length;
	assign target    = {hi_q, rdata};

	// Character push and chunk completion.
	assign push    = cmd.push_dot || cmd.push_byte;
	assign push_ch = cmd.push_dot ? DOT_CHAR : rdata;
	assign idx3    = (nlen_q[1:0] == 2'b11);

	// Status toward the controller.
	always_comb begin
		stat.at_end       = pos_ext >= blen_ext;
		stat.is_ptr       = rdata[7:6] == 2'b11;
		stat.ptr_trunc    = (pos_ext + CMP_W'(1)) >= blen_ext;
		stat.is_zero      = rdata == 8'h00;
		stat.bad_label    = (rdata[7:6] != 2'b00) || (label_end > blen_ext);
		stat.jump_over    = jump_q >= max_q;
		stat.rem_zero     = rem_q == '0;
		stat.name_full    = nlen_q >= NLEN_W'(NAME_BYTES - 1);
		stat.name_started = nlen_q != '0;
		stat.can_emit     = !out_valid_q || m_tready;
		stat.push_ok      = !idx3 || !out_valid_q || m_tready;
	end

	// Walk state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			blen_q  <= '0;
			jump_q  <= '0;
			max_q   <= JUMP_W'(10);
			rem_q   <= '0;
			nlen_q  <= '0;
			cons_q  <= '0;
			seen_q  <= 1'b0;
			chunk_q <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_value;
			end
			if (cmd.load) begin
				pos_q   <= POS_W'(in_address);
				blen_q  <= blen_next;
				jump_q  <= '0;
				rem_q   <= '0;
				nlen_q  <= '0;
				cons_q  <= '0;
				seen_q  <= 1'b0;
				chunk_q <= '0;
			end else if (cmd.take_zero) begin
				if (!seen_q) begin
					cons_q <= cons_q + CONS_W'(1);
				end
			end else if (cmd.take_label) begin
				pos_q <= pos_q + POS_W'(1);
				rem_q <= rdata[LABEL_W-1:0];
				if (!seen_q) begin
					cons_q <= cons_q + CONS_W'(1) + CONS_W'(rdata);
				end
			end else if (cmd.jump) begin
				pos_q  <= target;
				jump_q <= jump_q + JUMP_W'(1);
				if (!seen_q) begin
					cons_q <= cons_q + CONS_W'(2);
					seen_q <= 1'b1;
				end
			end else if (push) begin
				nlen_q <= nlen_q + NLEN_W'(1);
				if (idx3) begin
					chunk_q <= '0;
				end else begin
					chunk_q[{nlen_q[1:0], 3'b000} +: 8] <= push_ch;
				end
				if (cmd.push_byte) begin
					pos_q <= pos_q + POS_W'(1);
					rem_q <= rem_q - LABEL_W'(1);
				end
			end
		end
	end

	// High pointer bits, taken from the first pointer byte as the second one is read.
	always_ff @(posedge clk) begin
		if (cmd.rd_next) begin
			hi_q <= rdata[LABEL_W-1:0];
		end
	end

	assign cons_out = (cmd.fin_status == ST_OK) ? cons_q : '0;

	// Output register: full chunks while pushing, the tail on finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((push && idx3) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && idx3) begin
			out_data_q <= {1'b0, CONS_W'(0), ST_OK, 3'd4, push_ch, chunk_q};
			out_last_q <= 1'b0;
		end else if (cmd.finish) begin
			out_data_q <= {1'b0, cons_out, cmd.fin_status, {1'b0, nlen_q[1:0]}, 8'h00,
				chunk_q};
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/dnsd_ctrl.sv
`default_nettype none

module dnsd_ctrl import dnsd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output      logic  s_tready,
	input  wire logic  opcode,
	input  wire stat_t stat,
	output      cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_HDR,
		S_PTR,
		S_DOT,
		S_LFETCH,
		S_LCHAR,
		S_FINISH
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t status_q;
	status_t status_d;

	assign s_tready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		cmd            = '0;
		cmd.fin_status = status_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (opcode) begin
						cmd.load = 1'b1;
						state_d  = S_FETCH;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_FETCH: begin
				if (stat.at_end) begin
					status_d = ST_NO_END;
					state_d  = S_FINISH;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_HDR;
				end
			end
			S_HDR: begin
				if (stat.is_ptr) begin
					if (stat.ptr_trunc) begin
						status_d = ST_TRUNC_PTR;
						state_d  = S_FINISH;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = S_PTR;
					end
				end else if (stat.is_zero) begin
					cmd.take_zero = 1'b1;
					status_d      = ST_OK;
					state_d       = S_FINISH;
				end else if (stat.bad_label) begin
					status_d = ST_BAD_LABEL;
					state_d  = S_FINISH;
				end else begin
					cmd.take_label = 1'b1;
					if (!stat.name_started) begin
						state_d = S_LFETCH;
					end else if (stat.name_full) begin
						status_d = ST_TOO_LONG;
						state_d  = S_FINISH;
					end else begin
						state_d = S_DOT;
					end
				end
			end
			S_PTR: begin
				if (stat.jump_over) begin
					status_d = ST_JUMPS;
					state_d  = S_FINISH;
				end else begin
					cmd.jump = 1'b1;
					state_d  = S_FETCH;
				end
			end
			S_DOT: begin
				if (stat.push_ok) begin
					cmd.push_dot = 1'b1;
					state_d      = S_LFETCH;
				end
			end
			S_LFETCH: begin
				if (stat.rem_zero) begin
					state_d = S_FETCH;
				end else if (stat.name_full) begin
					status_d = ST_TOO_LONG;
					state_d  = S_FINISH;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_LCHAR;
				end
			end
			S_LCHAR: begin
				if (stat.push_ok) begin
					cmd.push_byte = 1'b1;
					state_d       = S_LFETCH;
				end
			end
			S_FINISH: begin
				if (stat.can_emit) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and completion code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/dns_name_decompressor_top.sv
`default_nettype none

`include "assert_macros.svh"

// DNS name decompressor. Load a message one byte per transfer (tuser 0), then
// request a decode at a start offset (tuser 1); the name comes out as dotted
// text, four characters per transfer, with tlast on the final transfer, which
// also carries the completion code and the bytes the name occupies at its
// start. A byte write leaves the input ready, so the next input transfer is
// accepted right away. A decode holds off input until its last result is loaded
// into the output register. The walk reads each name character and then pushes
// it; each label takes a header fetch, a header check and an end-of-label check,
// each dot a push, each compression pointer a fetch, a check and a jump, and a
// request is accepted, its closing zero byte read and its last result loaded,
// all paced by the single read port of the packet RAM and its registered read;
// output stalls hold the pushes and the last result, and an error ends the walk
// early. The jump limit is written through the cfg channel and resets to 10.
module dns_name_decompressor_top import dnsd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// s_tdata: address[11:0], data_byte[19:12], packet_length[32:20], zero fill
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: opcode
	input  wire logic                 s_tuser,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	// m_tdata: char0[7:0], char1[15:8], char2[23:16], char3[31:24],
	// char_count[34:32], status[37:35], consumed_bytes[46:38], zero fill
	output      logic [M_TDATA_W-1:0] m_tdata,
	output      logic                 m_tlast,
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [JUMP_W-1:0]    cfg_data,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready
);

	cmd_t  cmd;
	stat_t stat;

	// The jump limit register takes a write on any cycle.
	assign cfg_ready = 1'b1;

	dnsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	dnsd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_address       (s_tdata[11:0]),
		.in_data_byte     (s_tdata[19:12]),
		.in_packet_length (s_tdata[32:20]),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_value        (cfg_data),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast)
	);

	// Intermediate results are full chunks with a clean status.
	`ASSERT_IMPLY(a_body_full, clk, arst_n, m_tvalid && !m_tlast, (m_tdata[34:32] == 3'd4) && (m_tdata[37:35] == ST_OK))
	// The final result never carries a full chunk.
	`ASSERT_IMPLY(a_tail_short, clk, arst_n, m_tvalid && m_tlast, m_tdata[34:32] != 3'd4)
	// A failed decode reports no consumed bytes.
	`ASSERT_IMPLY(a_err_no_count, clk, arst_n, m_tvalid && (m_tdata[37:35] != ST_OK), m_tdata[46:38] == '0)
	// Starting a decode closes the input side on the next cycle.
	`ASSERT_NEXT(a_busy_after_load, clk, arst_n, cmd.load, !s_tready)

endmodule

`default_nettype wire

>>> test/tb_top.sv
module tb_top;
	import dnsd_pkg::*;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_DECODE = 1'b1;
	localparam int CYCLE_LIMIT = 2000000;

	// One output transfer as the decoder should present it.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [2:0]      count;
		logic            last;
		status_t         status;
		logic [8:0]      consumed;
	} name_chunk_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [JUMP_W-1:0]    cfg_data = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;

	// Shadow copy of the message memory and of the jump limit.
	bit [7:0]    shadow_mem [PACKET_BYTES];
	bit          byte_written [PACKET_BYTES];
	logic [7:0]  max_jumps = 8'd10;

	// Scratch state of one predicted name walk.
	name_chunk_t walk_out [$];
	bit          walk_touched;
	logic [31:0] pend_chars;
	int unsigned pend_len;

	name_chunk_t expected_chunks [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_len = 0;
	int          hold_left = 0;

	// Content of the random message currently loaded.
	logic [7:0]  msg_bytes [$];
	int unsigned name_starts [$];
	int unsigned label_starts [$];

	dns_name_decompressor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dns_name_decompressor_top verification failed");
			$finish;
		end
	end

	// Output ready: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare every output transfer with the oldest expected chunk.
	always @(posedge clk) begin : check_chunks
		name_chunk_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.chars    = m_tdata[31:0];
			got.count    = m_tdata[34:32];
			got.last     = m_tlast;
			got.status   = status_t'(m_tdata[37:35]);
			got.consumed = m_tdata[46:38];
			if (expected_chunks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected name chunk: tdata %h tlast %b", m_tdata, m_tlast);
			end else begin
				want = expected_chunks.pop_front();
				if (got.chars != want.chars || got.count != want.count ||
				    got.last != want.last || got.status != want.status ||
				    got.consumed != want.consumed) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("name chunk mismatch");
						$display("  expected chars %h count %0d last %0b status %0d consumed %0d",
						         want.chars, want.count, want.last, want.status,
						         want.consumed);
						$display("  got      chars %h count %0d last %0b status %0d consumed %0d",
						         got.chars, got.count, got.last, got.status,
						         got.consumed);
					end
				end
			end
		end
	end

	// Add one character to the name; every fourth one completes a chunk.
	function automatic void append_char(input logic [7:0] c);
		name_chunk_t ch;
		pend_chars[8*(pend_len%4) +: 8] = c;
		if (pend_len % 4 == 3) begin
			ch = '0;
			ch.chars = pend_chars;
			ch.count = 3'd4;
			ch.status = ST_OK;
			walk_out.push_back(ch);
			pend_chars = '0;
		end
		pend_len++;
	endfunction

	// Walk the name at start and collect the chunks it produces. Flags any
	// read of a byte that was never loaded.
	function automatic void predict_decode(input int unsigned start, input int unsigned plen);
		int unsigned blen, pos, jumps, used, lab;
		logic [7:0]  b;
		bit          via_ptr, done;
		status_t     st;
		name_chunk_t fin;
		walk_out.delete();
		walk_touched = 0;
		pend_chars = '0;
		pend_len = 0;
		blen = (plen > PACKET_BYTES) ? PACKET_BYTES : plen;
		pos = start;
		jumps = 0;
		used = 0;
		via_ptr = 0;
		done = 0;
		st = ST_NO_END;
		while (!done && pos < blen) begin
			walk_touched |= !byte_written[pos];
			b = shadow_mem[pos];
			if (b[7:6] == 2'b11) begin
				// Compression pointer.
				if (pos + 1 >= blen) begin
					st = ST_TRUNC_PTR;
					done = 1;
				end else begin
					walk_touched |= !byte_written[pos+1];
					if (!via_ptr) begin
						used += 2;
						via_ptr = 1;
					end
					if (jumps >= max_jumps) begin
						st = ST_JUMPS;
						done = 1;
					end else begin
						jumps++;
						pos = {b[5:0], shadow_mem[pos+1]};
					end
				end
			end else if (b == 8'd0) begin
				if (!via_ptr)
					used += 1;
				st = ST_OK;
				done = 1;
			end else if (b > 8'd63 || pos + 1 + b > blen) begin
				st = ST_BAD_LABEL;
				done = 1;
			end else begin
				// Ordinary label, preceded by a dot unless it is the first.
				if (!via_ptr)
					used += 1 + b;
				if (pend_len > 0) begin
					if (pend_len + 1 >= NAME_BYTES) begin
						st = ST_TOO_LONG;
						done = 1;
					end else begin
						append_char(DOT_CHAR);
					end
				end
				pos++;
				for (lab = b; lab > 0 && !done; lab--) begin
					if (pend_len + 1 >= NAME_BYTES) begin
						st = ST_TOO_LONG;
						done = 1;
					end else begin
						walk_touched |= !byte_written[pos];
						append_char(shadow_mem[pos]);
						pos++;
					end
				end
			end
		end
		fin = '0;
		fin.chars = pend_chars;
		fin.count = 3'(pend_len % 4);
		fin.last = 1'b1;
		fin.status = st;
		fin.consumed = (st == ST_OK) ? 9'(used) : 9'd0;
		walk_out.push_back(fin);
	endfunction

	// Offer one item and wait for its transfer. A decode queues the chunks
	// that the last call of predict_decode worked out.
	task automatic send_item(input logic op, input logic [11:0] addr,
	                         input logic [7:0] data, input logic [12:0] plen);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tuser <= op;
		s_tdata <= {7'd0, plen, data, addr};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_WRITE) begin
			shadow_mem[addr] = data;
			byte_written[addr] = 1;
		end else begin
			foreach (walk_out[i])
				expected_chunks.push_back(walk_out[i]);
		end
	endtask

	task automatic request_decode(input int unsigned addr, input int unsigned plen);
		predict_decode(addr, plen);
		if (!walk_touched)
			send_item(OP_DECODE, 12'(addr), 8'($urandom_range(255)), 13'(plen));
	endtask

	// Stop offering input and wait until every expected chunk has arrived.
	task automatic finish_pending(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_chunks.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_jump_limit(input logic [7:0] value);
		finish_pending(10);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		max_jumps = value;
	endtask

	// Random message: names of random labels ending in a zero label, a pointer
	// to an earlier label, or now and then an oversized label or stray pointer.
	function automatic void build_message(input int unsigned base, input int unsigned len);
		int unsigned nlab, llen, r, k, tgt;
		msg_bytes.delete();
		name_starts.delete();
		label_starts.delete();
		while (msg_bytes.size() + 8 <= len) begin
			name_starts.push_back(base + msg_bytes.size());
			nlab = $urandom_range(4);
			for (k = 0; k < nlab; k++) begin
				llen = ($urandom_range(9) == 0) ? $urandom_range(63, 40) : $urandom_range(12, 1);
				if (msg_bytes.size() + llen + 3 > len)
					break;
				label_starts.push_back(base + msg_bytes.size());
				msg_bytes.push_back(8'(llen));
				repeat (llen) msg_bytes.push_back(8'($urandom_range(255)));
			end
			r = $urandom_range(99);
			if (r < 55 || label_starts.size() == 0) begin
				msg_bytes.push_back(8'h00);
			end else if (r < 88) begin
				tgt = label_starts[$urandom_range(label_starts.size() - 1)];
				msg_bytes.push_back(8'hC0 | 8'(tgt >> 8));
				msg_bytes.push_back(8'(tgt));
			end else if (r < 94) begin
				msg_bytes.push_back(8'($urandom_range(191, 64)));
			end else begin
				msg_bytes.push_back(8'hC0 | 8'($urandom_range(63)));
				msg_bytes.push_back(8'($urandom_range(255)));
			end
		end
		while (msg_bytes.size() < len)
			msg_bytes.push_back(8'h00);
	endfunction

	// Hand-built message covering each kind of name and each completion code except ST_TOO_LONG.
	task automatic test_directed_names();
		logic [7:0] image [$];
		send_gap_pct = 0;
		recv_stall_pct = 0;
		image = '{8'd3, "w", "w", "w", 8'd7, "e", "x", "a", "m", "p", "l", "e",
		          8'd3, "c", "o", "m", 8'd0,
		          8'd0,
		          8'd4, "m", "a", "i", "l", 8'hC0, 8'd4,
		          8'hC0, 8'd18,
		          8'h40, 8'hBF,
		          8'hC0, 8'd29,
		          8'd1, "z",
		          8'hC1,
		          8'hFF, 8'hFF,
		          8'd1, "a", 8'hC0, 8'd36};
		foreach (image[i])
			send_item(OP_WRITE, 12'(i), image[i], 13'($urandom_range(8191)));
		send_item(OP_WRITE, 12'd4095, 8'h00, 13'd8191);
		request_decode(0, 40);       // plain name
		request_decode(17, 40);      // root name
		request_decode(18, 40);      // label then pointer
		request_decode(25, 40);      // pointer to a name that ends in a pointer
		request_decode(27, 40);      // label length 64
		request_decode(28, 40);      // label byte 0xBF
		request_decode(29, 40);      // pointer to itself
		request_decode(31, 33);      // label ends exactly at the end, no terminator
		request_decode(31, 32);      // label runs past the end
		request_decode(33, 34);      // pointer cut off by the end
		request_decode(34, 40);      // pointer far past the end
		request_decode(36, 40);      // label and pointer loop
		request_decode(4095, 4096);  // root at the last address
		request_decode(4095, 8191);  // oversized length saturates
		request_decode(4095, 4095);  // start at the end
		request_decode(0, 0);        // empty packet
		request_decode(0, 8191);
	endtask

	task automatic test_jump_limit();
		set_jump_limit(8'd0);
		request_decode(36, 40);
		request_decode(25, 40);
		request_decode(0, 40);
		set_jump_limit(8'd1);
		request_decode(25, 40);
		request_decode(18, 40);
		set_jump_limit(8'd255);
		request_decode(36, 40);      // name grows past the buffer
		request_decode(29, 40);      // full 255 jumps, then rejected
	endtask

	// Hold the output off for a long stretch while decodes keep coming.
	task automatic test_output_hold_off();
		finish_pending(2);
		hold_len = 600;
		request_decode(36, 40);
		request_decode(36, 40);
		request_decode(0, 40);
		request_decode(36, 40);
		request_decode(18, 40);
		finish_pending(2);
	endtask

	// Rounds of one random message load followed by decodes into it.
	task automatic test_random_messages(input int gap_pct, input int stall_pct,
	                                    input logic [7:0] limit, input int item_goal);
		int          sent, tries;
		int unsigned base, len, r, addr, plen;
		set_jump_limit(limit);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < item_goal) begin
			len = $urandom_range(100, 24);
			base = $urandom_range(PACKET_BYTES - len);
			build_message(base, len);
			foreach (msg_bytes[i]) begin
				send_item(OP_WRITE, 12'(base + i), msg_bytes[i], 13'($urandom_range(8191)));
				sent++;
			end
			repeat ($urandom_range(14, 6)) begin
				for (tries = 0; tries < 8; tries++) begin
					r = $urandom_range(99);
					if (r < 65)
						addr = name_starts[$urandom_range(name_starts.size() - 1)];
					else if (r < 80 && label_starts.size() != 0)
						addr = label_starts[$urandom_range(label_starts.size() - 1)];
					else
						addr = base + $urandom_range(len - 1);
					r = $urandom_range(99);
					if (r < 70)
						plen = base + len;
					else if (r < 85)
						plen = $urandom_range(base + len, addr);
					else
						plen = $urandom_range(8191);
					predict_decode(addr, plen);
					if (!walk_touched)
						break;
				end
				if (!walk_touched) begin
					send_item(OP_DECODE, 12'(addr), 8'($urandom_range(255)), 13'(plen));
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_names();
		test_jump_limit();
		test_output_hold_off();
		test_random_messages(0, 0, 8'd10, 64);
		test_random_messages(85, 0, 8'd0, 64);
		test_random_messages(0, 85, 8'd255, 64);
		test_random_messages(33, 33, 8'($urandom_range(30, 1)), 64);
		finish_pending(50);
		if (mismatch_count == 0 && expected_chunks.size() == 0)
			$display("dns_name_decompressor_top verification clean");
		else
			$display("dns_name_decompressor_top verification failed");
		$finish;
	end

endmodule
